// ----- design/pdlr_pkg.sv -----
// ----------------------------------------------------------------------------
// pdlr_pkg
// Shared constants and widths for the mono downmix / linear resampler.
// ----------------------------------------------------------------------------
package pdlr_pkg;

    localparam int MAX_CHANNELS    = 8;
    localparam int PHASE_FRAC_BITS = 24;
    localparam int PHASE_W         = PHASE_FRAC_BITS + 2;
    localparam int MAX_RESULTS     = 7;
    localparam int FRAME_SAMPLES_D = 960;

    localparam int WORD_W  = 32;
    localparam int CHV_W   = 24;   // one channel in Q16.8
    localparam int SUM_W   = 28;   // sum of all channels
    localparam int MONO_W  = 25;   // mono value in Q16.8
    localparam int QUO_W   = SUM_W - 1;
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = (PHASE_FRAC_BITS > 15) ? PHASE_FRAC_BITS : 15;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = PHASE_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_FORMAT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_STEP    = 2'd2;

    localparam logic [1:0] FMT_FLOAT32 = 2'd0;
    localparam logic [1:0] FMT_PCM16   = 2'd1;
    localparam logic [1:0] FMT_PCM24   = 2'd2;
    localparam logic [1:0] FMT_PCM32   = 2'd3;

    localparam logic signed [CHV_W-1:0] FULL_Q8 = 24'sd8388352;

endpackage

// ----- design/pdlr_if.sv -----
// ----------------------------------------------------------------------------
// pdlr_in_if / pdlr_out_if
// Valid/ready channels carrying input frames and output samples.
// ----------------------------------------------------------------------------
interface pdlr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] chan0_word;
    logic [31:0] chan1_word;
    logic [31:0] chan2_word;
    logic [31:0] chan3_word;
    logic [31:0] chan4_word;
    logic [31:0] chan5_word;
    logic [31:0] chan6_word;
    logic [31:0] chan7_word;
    logic        silent;

    modport source (output valid, chan0_word, chan1_word, chan2_word, chan3_word,
                    chan4_word, chan5_word, chan6_word, chan7_word, silent,
                    input ready);
    modport sink   (input valid, chan0_word, chan1_word, chan2_word, chan3_word,
                    chan4_word, chan5_word, chan6_word, chan7_word, silent,
                    output ready);
endinterface

interface pdlr_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_sample;
    logic               run_last;
    logic               frame_end;

    modport source (output valid, out_sample, run_last, frame_end, input ready);
    modport sink   (input valid, out_sample, run_last, frame_end, output ready);
endinterface

// ----- design/pdlr_mul.sv -----
// ----------------------------------------------------------------------------
// pdlr_mul
// Shared registered multiplier: signed operand times unsigned operand.
// ----------------------------------------------------------------------------
module pdlr_mul
    import pdlr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic        [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * $signed({1'b0, i_b});
        end
    end

    assign o_p = r_p;

endmodule

// ----- design/pdlr_div.sv -----
// ----------------------------------------------------------------------------
// pdlr_div
// Bit-serial restoring divider: channel sum by channel count, toward zero.
// ----------------------------------------------------------------------------
module pdlr_div
    import pdlr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [SUM_W-1:0]  i_dividend,
    input  logic        [3:0]        i_divisor,
    output logic                     o_done,
    output logic signed [MONO_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(QUO_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [4:0]       r_rem;
    logic [QUO_W-1:0] r_quo;
    logic [3:0]       r_dvs;
    logic             r_neg;

    logic [SUM_W-1:0] mag;
    logic [4:0]       trial;
    logic             fits;

    assign mag   = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
    assign trial = {r_rem[3:0], r_quo[QUO_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= mag[QUO_W-1:0];
                r_dvs  <= i_divisor;
                r_neg  <= i_dividend[SUM_W-1];
            end else if (r_busy) begin
                r_rem <= fits ? trial - {1'b0, r_dvs} : trial;
                r_quo <= {r_quo[QUO_W-2:0], fits};
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo[MONO_W-1:0]) : $signed(r_quo[MONO_W-1:0]);

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without a division");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held longer than a cycle");

endmodule

// ----- design/pcm_downmix_linear_resampler.sv -----
// ----------------------------------------------------------------------------
// pcm_downmix_linear_resampler
// Multichannel PCM/float frame to 48 kHz mono int16 via linear interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one multichannel frame per request; o_out carries zero to
//   seven mono samples per frame, run_last on the last one of each frame and
//   frame_end on every FRAME_SAMPLES-th sample.
//   Registers (sample_format, channel_count, phase_step) are written through
//   i_cfg_we / i_cfg_addr / i_cfg_data while the block is idle.
// Sequence:
//   a frame passes through idle, which takes the request, a multiply and an add per
//   active channel for scaling, the bit-serial mono divide and its hand-off
//   (silent frames skip both), a check state, and per emitted sample a
//   multiply, an add/clamp and a present state. The shared multiplier and the
//   serial divider set this order; i_in.ready is high only between frames.
// Reset:
//   clears the cursor, previous mono value and frame counter and loads the
//   register defaults (pcm16, two channels, step 1.0).
// Stall:
//   a sample waits in the output register while o_out.ready is low; the
//   sequencer holds and accepts no new frame until the run is delivered.
// ----------------------------------------------------------------------------
module pcm_downmix_linear_resampler
    import pdlr_pkg::*;
#(
    parameter int FRAME_SAMPLES = FRAME_SAMPLES_D
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pdlr_in_if.sink               i_in,
    pdlr_out_if.source            o_out
);

    localparam int FILL_W = $clog2(FRAME_SAMPLES + 1);
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ACC_W  = MUL_P_W + 1;
    localparam logic [PHASE_W:0] ONE = (PHASE_W + 1)'(1) << PHASE_FRAC_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMUL = 3'd1;
    localparam logic [2:0] S_CADD = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_IMUL = 3'd5;
    localparam logic [2:0] S_IADD = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0]               r_state;
    logic [1:0]               r_fmt;
    logic [3:0]               r_ccnt;
    logic [PHASE_W-1:0]       r_step;
    logic [PHASE_W-1:0]       r_phase;
    logic signed [MONO_W-1:0] r_prev;
    logic signed [MONO_W-1:0] r_cur;
    logic [FILL_W-1:0]        r_fill;
    logic [WORD_W-1:0]        r_words [MAX_CHANNELS];
    logic                     r_silent;
    logic [CH_W-1:0]          r_ch;
    logic signed [SUM_W-1:0]  r_sum;
    logic [2:0]               r_count;
    logic                     r_ovalid;
    logic signed [15:0]       r_osample;
    logic                     r_olast;
    logic                     r_ofe;

    // channel count clamped to 1..MAX_CHANNELS
    logic [3:0] n_eff;
    always_comb begin
        if (r_ccnt == 4'd0) begin
            n_eff = 4'd1;
        end else if (r_ccnt > 4'(MAX_CHANNELS)) begin
            n_eff = 4'(MAX_CHANNELS);
        end else begin
            n_eff = r_ccnt;
        end
    end

    // current channel word and its float fields
    logic [WORD_W-1:0] w;
    logic [7:0]        f_exp;
    logic [22:0]       f_man;
    assign w     = r_words[r_ch];
    assign f_exp = w[30:23];
    assign f_man = w[22:0];

    // shared multiplier operands
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic        [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic signed [MONO_W:0]    diff;

    assign diff   = (MONO_W + 1)'(r_cur) - (MONO_W + 1)'(r_prev);
    assign mul_en = (r_state == S_CMUL) || (r_state == S_IMUL);

    always_comb begin
        if (r_state == S_IMUL) begin
            mul_a = MUL_A_W'(diff);
            mul_b = MUL_B_W'(r_phase[PHASE_FRAC_BITS-1:0]);
        end else begin
            mul_a = MUL_A_W'($signed({1'b0, (f_exp != 8'd0), f_man}));
            mul_b = MUL_B_W'(15'd32767);
        end
    end

    pdlr_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // channel scaling to Q16.8
    logic [7:0]              f_sh;
    logic [38:0]             f_mag;
    logic signed [CHV_W-1:0] chv;
    logic signed [32:0]      p32;

    assign f_sh  = 8'd142 - ((f_exp != 8'd0) ? f_exp : 8'd1);
    assign f_mag = (f_sh >= 8'd39) ? 39'd0 : (prod[38:0] >> f_sh);
    assign p32   = $signed({w[31], w}) + (w[31] ? 33'sd255 : 33'sd0);

    always_comb begin
        case (r_fmt)
            FMT_FLOAT32: begin
                if (f_exp == 8'hFF && f_man != 23'd0) begin
                    chv = '0;
                end else if (f_exp >= 8'd127) begin
                    chv = w[31] ? -FULL_Q8 : FULL_Q8;
                end else begin
                    chv = w[31] ? -$signed(f_mag[CHV_W-1:0]) : $signed(f_mag[CHV_W-1:0]);
                end
            end
            FMT_PCM16: chv = $signed({w[15:0], 8'd0});
            FMT_PCM24: chv = $signed(w[23:0]);
            FMT_PCM32: chv = $signed(p32[31:8]);
            default:   chv = '0;
        endcase
    end

    logic signed [SUM_W-1:0] n_sum;
    logic                    last_ch;
    assign n_sum   = r_sum + SUM_W'(chv);
    assign last_ch = ({1'b0, 4'(r_ch)} + 5'd1) >= {1'b0, n_eff};

    logic                     div_done;
    logic signed [MONO_W-1:0] div_q;

    pdlr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((r_state == S_CADD) && last_ch),
        .i_dividend (n_sum),
        .i_divisor  (n_eff),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // interpolation: prev * 2^F + diff * frac, then toward-zero shift and clamp
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] adj;
    logic signed [ACC_W-PHASE_FRAC_BITS-9:0] v;
    logic signed [15:0]      sat;

    assign acc = (ACC_W'(r_prev) <<< PHASE_FRAC_BITS) + ACC_W'(prod);
    assign adj = acc + (acc[ACC_W-1] ? ACC_W'((64'd1 << (PHASE_FRAC_BITS + 8)) - 1) : '0);
    assign v   = adj[ACC_W-1:PHASE_FRAC_BITS+8];

    always_comb begin
        if (v >= 32767) begin
            sat = 16'sd32767;
        end else if (v <= -32768) begin
            sat = -16'sd32768;
        end else begin
            sat = v[15:0];
        end
    end

    logic [PHASE_W:0]  next_pos;
    logic              run_end;
    logic [FILL_W-1:0] n_fill;
    assign next_pos = {1'b0, r_phase} + {1'b0, r_step};
    assign run_end  = (next_pos >= ONE) || (r_count == 3'(MAX_RESULTS - 1));
    assign n_fill   = r_fill + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fmt    <= FMT_PCM16;
            r_ccnt   <= 4'd2;
            r_step   <= PHASE_W'(ONE);
            r_phase  <= '0;
            r_prev   <= '0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SAMPLE_FORMAT: r_fmt  <= i_cfg_data[1:0];
                    CFG_CHANNEL_COUNT: r_ccnt <= i_cfg_data[3:0];
                    CFG_PHASE_STEP:    r_step <= i_cfg_data[PHASE_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_words[0] <= i_in.chan0_word;
                        r_words[1] <= i_in.chan1_word;
                        r_words[2] <= i_in.chan2_word;
                        r_words[3] <= i_in.chan3_word;
                        r_words[4] <= i_in.chan4_word;
                        r_words[5] <= i_in.chan5_word;
                        r_words[6] <= i_in.chan6_word;
                        r_words[7] <= i_in.chan7_word;
                        r_silent   <= i_in.silent;
                        r_ch       <= '0;
                        r_sum      <= '0;
                        r_cur      <= '0;
                        r_state    <= i_in.silent ? S_CHK : S_CMUL;
                    end
                end
                S_CMUL: r_state <= S_CADD;
                S_CADD: begin
                    r_sum <= n_sum;
                    r_ch  <= r_ch + 1'b1;
                    r_state <= last_ch ? S_DIV : S_CMUL;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_cur   <= div_q;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_count <= '0;
                    if ({1'b0, r_phase} >= ONE) begin
                        r_phase <= PHASE_W'({1'b0, r_phase} - ONE);
                        r_prev  <= r_cur;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_IMUL;
                    end
                end
                S_IMUL: r_state <= S_IADD;
                S_IADD: begin
                    r_osample <= r_silent ? 16'sd0 : sat;
                    r_olast   <= run_end;
                    if (n_fill >= FILL_W'(FRAME_SAMPLES)) begin
                        r_fill <= '0;
                        r_ofe  <= 1'b1;
                    end else begin
                        r_fill <= n_fill;
                        r_ofe  <= 1'b0;
                    end
                    r_ovalid <= 1'b1;
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    if (o_out.ready) begin
                        r_ovalid <= 1'b0;
                        if (r_olast) begin
                            r_phase <= (next_pos >= ONE) ? PHASE_W'(next_pos - ONE) : '0;
                            r_prev  <= r_cur;
                            r_state <= S_IDLE;
                        end else begin
                            r_phase <= PHASE_W'(next_pos);
                            r_count <= r_count + 1'b1;
                            r_state <= S_IMUL;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_ovalid;
    assign o_out.out_sample = r_osample;
    assign o_out.run_last   = r_olast;
    assign o_out.frame_end  = r_ofe;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid) else $error("frame taken while a sample pending");
    a_frame_end_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_end) |-> (r_fill == '0))
        else $error("frame_end without counter restart");
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_count == 3'(MAX_RESULTS - 1)) |-> o_out.run_last)
        else $error("run exceeds result limit");
    a_phase_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IMUL) |-> ({1'b0, r_phase} < ONE))
        else $error("interpolating past the current frame");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives multichannel frames into the downmix resampler under several
// register settings, predicts each mono int16 sample with run and frame
// marks, and compares every output request against that prediction.
// ----------------------------------------------------------------------------
module testbench;
    import pdlr_pkg::*;

    localparam longint PHASE_ONE  = longint'(1) << PHASE_FRAC_BITS;
    localparam longint PHASE_MASK = (longint'(1) << PHASE_W) - 1;
    localparam int     SETTLE     = 120;
    localparam int     CYCLE_CAP  = 600000;

    typedef struct {
        logic [31:0] word [MAX_CHANNELS];
        bit          silent;
    } t_frame;

    typedef struct {
        logic signed [15:0] sample;
        bit                 last;
        bit                 fend;
    } t_mono_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = CFG_SAMPLE_FORMAT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pdlr_in_if  in_if();
    pdlr_out_if out_if();

    pcm_downmix_linear_resampler uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data),
        .i_in       (in_if.sink),
        .o_out      (out_if.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // register mirror and resampler state
    logic [1:0]  fmt_reg  = FMT_PCM16;
    logic [3:0]  chan_reg = 4'd2;
    logic [25:0] step_reg = 26'd16777216;
    longint      cursor   = 0;
    longint      prev_q8  = 0;
    int          fill_cnt = 0;

    t_frame      frames_pending [$];
    t_mono_out   samples_due [$];
    int          frames_queued = 0;
    int          frames_taken  = 0;
    int          samples_seen  = 0;
    int          mismatches    = 0;
    int          cycles        = 0;
    int          hold_left     = 0;
    bit          hold_done     = 0;

    function automatic longint float_to_q8(logic [31:0] w);
        logic [7:0]  e;
        logic [22:0] m;
        longint      mant, mag;
        int          sh;
        e = w[30:23];
        m = w[22:0];
        if (e == 8'hFF && m != 0) return 0;
        if (e >= 8'd127) return w[31] ? -longint'(FULL_Q8) : longint'(FULL_Q8);
        mant = (e != 0) ? longint'({1'b1, m}) : longint'(m);
        sh = 142 - ((e != 0) ? int'(e) : 1);
        mag = (sh >= 64) ? 0 : ((mant * 32767) >>> sh);
        return w[31] ? -mag : mag;
    endfunction

    function automatic longint chan_to_q8(logic [31:0] w);
        case (fmt_reg)
            FMT_FLOAT32: return float_to_q8(w);
            FMT_PCM16:   return longint'($signed(w[15:0])) * 256;
            FMT_PCM24:   return longint'($signed(w[23:0]));
            default:     return longint'($signed(w)) / 256;
        endcase
    endfunction

    task automatic predict_frame(input t_frame f);
        t_mono_out run [MAX_RESULTS];
        longint    cur, pos, sum, acc, v;
        int        n, cnt;
        n = (chan_reg == 0) ? 1 : ((chan_reg > MAX_CHANNELS) ? MAX_CHANNELS : int'(chan_reg));
        sum = 0;
        for (int ch = 0; ch < n; ch++) sum += chan_to_q8(f.word[ch]);
        cur = f.silent ? 0 : sum / n;
        pos = cursor;
        cnt = 0;
        while (pos < PHASE_ONE && cnt < MAX_RESULTS) begin
            if (f.silent) begin
                v = 0;
            end else begin
                acc = prev_q8 * PHASE_ONE + (cur - prev_q8) * pos;
                v = acc / (longint'(1) << (PHASE_FRAC_BITS + 8));
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
            end
            fill_cnt++;
            run[cnt].fend = 0;
            if (fill_cnt >= FRAME_SAMPLES_D) begin
                fill_cnt = 0;
                run[cnt].fend = 1;
            end
            run[cnt].sample = v[15:0];
            run[cnt].last = 0;
            cnt++;
            pos += step_reg;
        end
        if (pos < PHASE_ONE) pos = PHASE_ONE;
        cursor = (pos - PHASE_ONE) & PHASE_MASK;
        prev_q8 = cur;
        if (cnt > 0) run[cnt-1].last = 1;
        for (int k = 0; k < cnt; k++) samples_due.push_back(run[k]);
    endtask

    // steady stretch with no idling on either side
    function automatic bit take_break();
        if (frames_taken >= 150 && frames_taken < 220) return 0;
        return $urandom_range(99) < 11;
    endfunction

    initial begin
        in_if.valid = 1'b0;
        in_if.silent = 1'b0;
        in_if.chan0_word = '0; in_if.chan1_word = '0; in_if.chan2_word = '0;
        in_if.chan3_word = '0; in_if.chan4_word = '0; in_if.chan5_word = '0;
        in_if.chan6_word = '0; in_if.chan7_word = '0;
        out_if.ready = 1'b0;
    end

    // frame driver
    always @(posedge i_clk) begin
        t_frame f;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (frames_pending.size() > 0 && !take_break()) begin
                f = frames_pending.pop_front();
                in_if.chan0_word <= f.word[0]; in_if.chan1_word <= f.word[1];
                in_if.chan2_word <= f.word[2]; in_if.chan3_word <= f.word[3];
                in_if.chan4_word <= f.word[4]; in_if.chan5_word <= f.word[5];
                in_if.chan6_word <= f.word[6]; in_if.chan7_word <= f.word[7];
                in_if.silent <= f.silent;
                in_if.valid <= 1'b1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // accepted request -> prediction
    always @(posedge i_clk) begin
        t_frame f;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            f.word[0] = in_if.chan0_word; f.word[1] = in_if.chan1_word;
            f.word[2] = in_if.chan2_word; f.word[3] = in_if.chan3_word;
            f.word[4] = in_if.chan4_word; f.word[5] = in_if.chan5_word;
            f.word[6] = in_if.chan6_word; f.word[7] = in_if.chan7_word;
            f.silent = in_if.silent;
            predict_frame(f);
            frames_taken++;
        end
    end

    // output ready, with one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else if (!hold_done && frames_taken >= 60) begin
            hold_done <= 1;
            hold_left <= 400;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= !take_break();
        end
    end

    // output checker
    always @(posedge i_clk) begin
        t_mono_out exp_s;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            samples_seen++;
            if (samples_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sample %0d last=%0b fend=%0b", out_if.out_sample,
                             out_if.run_last, out_if.frame_end);
            end else begin
                exp_s = samples_due.pop_front();
                if (out_if.out_sample !== exp_s.sample || out_if.run_last !== exp_s.last ||
                    out_if.frame_end !== exp_s.fend) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sample %0d: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                 samples_seen, exp_s.sample, exp_s.last, exp_s.fend,
                                 out_if.out_sample, out_if.run_last, out_if.frame_end);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic queue_frame(input t_frame f);
        frames_pending.push_back(f);
        frames_queued++;
    endtask

    task automatic queue_all(input logic [31:0] w, input bit silent);
        t_frame f;
        for (int ch = 0; ch < MAX_CHANNELS; ch++) f.word[ch] = w;
        f.silent = silent;
        queue_frame(f);
    endtask

    function automatic logic [31:0] rand_word();
        if (fmt_reg == FMT_FLOAT32 && $urandom_range(1)) begin
            // mostly below full scale, down to about 2^-17, some at or beyond one
            return {1'($urandom_range(1)), 8'($urandom_range(128, 110)),
                    23'($urandom)};
        end
        return $urandom;
    endfunction

    task automatic queue_random(input int count);
        t_frame f;
        for (int i = 0; i < count; i++) begin
            for (int ch = 0; ch < MAX_CHANNELS; ch++) f.word[ch] = rand_word();
            f.silent = ($urandom_range(9) == 0);
            queue_frame(f);
        end
    endtask

    task automatic drain();
        while (frames_taken != frames_queued || samples_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [25:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SAMPLE_FORMAT: fmt_reg = val[1:0];
            CFG_CHANNEL_COUNT: chan_reg = val[3:0];
            default:           step_reg = val;
        endcase
    endtask

    task automatic set_regs(input logic [1:0] fmt, input logic [3:0] cnt,
                            input logic [25:0] step);
        drain();
        write_reg(CFG_SAMPLE_FORMAT, fmt);
        write_reg(CFG_CHANNEL_COUNT, cnt);
        write_reg(CFG_PHASE_STEP, step);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: pcm16, two channels, unit step
        queue_all(32'h0000_7FFF, 0);
        queue_all(32'hFFFF_8000, 0);
        queue_all(32'h1234_5678, 1);
        queue_all(32'h0000_0000, 0);

        // floats: infinities, nan, denormal, one, beyond one, half
        set_regs(FMT_FLOAT32, 4'd8, 26'd15_052_827);
        queue_all(32'h7F80_0000, 0);
        queue_all(32'hFF80_0000, 0);
        queue_all(32'h7FC0_0000, 0);
        queue_all(32'h0000_0001, 0);
        queue_all(32'h3F80_0000, 0);
        queue_all(32'hC000_0000, 0);
        queue_all(32'h3F00_0000, 0);
        queue_all(32'h8000_0000, 0);

        // zero channel count, tiny step forces seven samples per frame
        set_regs(FMT_PCM24, 4'd0, 26'd1);
        queue_all(32'h0080_0000, 0);
        queue_all(32'h007F_FFFF, 0);
        queue_all(32'hFF00_0000, 1);

        // channel count above limit, largest step skips most frames
        set_regs(FMT_PCM32, 4'd15, 26'h3FF_FFFF);
        queue_all(32'h8000_0000, 0);
        queue_all(32'h7FFF_FFFF, 0);
        queue_all(32'hFFFF_FFFF, 0);
        queue_all(32'h0000_00FF, 0);
        queue_all(32'h1234_5678, 0);

        set_regs(FMT_PCM16, 4'd1, 26'd1);
        queue_random(40);
        set_regs(FMT_FLOAT32, 4'd2, 26'd15_414_067);
        queue_random(40);
        set_regs(FMT_PCM24, 4'd6, 26'd33_554_432);
        queue_random(35);
        set_regs(FMT_PCM32, 4'd8, 26'd2_400_000);
        queue_random(40);
        set_regs(FMT_PCM16, 4'd3, 26'h3FF_FFFF);
        queue_random(30);
        set_regs(FMT_FLOAT32, 4'd5, 26'd7_000_000);
        queue_random(40);
        set_regs(FMT_PCM24, 4'd15, 26'($urandom_range(67108863, 1)));
        queue_random(35);
        set_regs(FMT_PCM32, 4'd0, 26'd16_777_216);
        queue_random(40);

        drain();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/pdlr_pkg.sv
design/pdlr_if.sv
design/pdlr_mul.sv
design/pdlr_div.sv
design/pcm_downmix_linear_resampler.sv
tb/testbench.sv
